/* sv/abr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package abr_pkg;

    localparam int MAX_K_DEF     = 16;
    localparam int VALUE_W       = 32;
    localparam int LEN_W         = 5;
    localparam logic [LEN_W-1:0] BLOCK_LEN_RST = LEN_W'(2);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef struct packed {
        logic accept;
        logic read_step;
    } t_cmd;

    typedef struct packed {
        logic go_drain;
        logic pass_phase;
        logic more;
    } t_sts;

endpackage

`default_nettype wire

/* sv/abr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module abr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire abr_pkg::t_sts i_sts,
    output abr_pkg::t_cmd      o_cmd
);

    abr_pkg::t_state r_state;
    abr_pkg::t_state n_state;
    logic            w_accept;

    assign o_in_ready  = (r_state == abr_pkg::S_IDLE);
    assign o_out_valid = (r_state == abr_pkg::S_OUT);
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.accept    = w_accept;
        o_cmd.read_step = (r_state == abr_pkg::S_READ);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            abr_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_sts.go_drain) begin
                        n_state = abr_pkg::S_READ;
                    end else if (i_sts.pass_phase) begin
                        n_state = abr_pkg::S_OUT;
                    end
                end
            end
            abr_pkg::S_READ: begin
                n_state = abr_pkg::S_OUT;
            end
            abr_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_state = i_sts.more ? abr_pkg::S_READ : abr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = abr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_read_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == abr_pkg::S_READ |=> r_state == abr_pkg::S_OUT)
        else $error("read step not followed by output beat");

    a_drain_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_sts.go_drain) |=> r_state == abr_pkg::S_READ)
        else $error("drain did not start after full block");

endmodule

`default_nettype wire

/* sv/abr_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module abr_datapath #(
    parameter int MAX_K = abr_pkg::MAX_K_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire abr_pkg::t_cmd                 i_cmd,
    output abr_pkg::t_sts                      o_sts,
    input  wire logic                          i_cfg_valid,
    input  wire logic [abr_pkg::LEN_W-1:0]     i_cfg_block_len,
    input  wire logic signed [abr_pkg::VALUE_W-1:0] i_value,
    input  wire logic                          i_list_end,
    output logic signed [abr_pkg::VALUE_W-1:0] o_value_res,
    output logic                               o_run_last,
    output logic                               o_list_done
);

    localparam int CW = $clog2(MAX_K + 1);
    localparam int AW = $clog2(MAX_K);
    localparam int KW = (CW > abr_pkg::LEN_W) ? CW : abr_pkg::LEN_W;

    logic [abr_pkg::LEN_W-1:0]   r_block_len;
    logic [CW-1:0]               r_fill;
    logic [CW-1:0]               r_pass;
    logic                        r_phase;
    logic                        r_end;
    logic [abr_pkg::VALUE_W-1:0] r_mem [MAX_K];
    logic [abr_pkg::VALUE_W-1:0] r_out_value;
    logic                        r_out_last;
    logic                        r_out_done;

    logic [KW-1:0] w_len;
    logic [KW-1:0] w_k;
    logic [KW:0]   w_fill_inc;
    logic [KW:0]   w_pass_inc;
    logic          w_pass_end;
    logic [CW-1:0] n_fill_dec;

    assign w_len      = KW'(r_block_len);
    assign w_k        = (w_len > KW'(MAX_K)) ? KW'(MAX_K) : w_len;
    assign w_fill_inc = (KW + 1)'(r_fill) + (KW + 1)'(1);
    assign w_pass_inc = (KW + 1)'(r_pass) + (KW + 1)'(1);
    assign w_pass_end = (w_pass_inc >= (KW + 1)'(w_k)) || i_list_end;
    assign n_fill_dec = r_fill - CW'(1);

    always_comb begin
        o_sts.go_drain   = r_phase && ((w_fill_inc >= (KW + 1)'(w_k)) || i_list_end);
        o_sts.pass_phase = !r_phase;
        o_sts.more       = (r_fill != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_len <= abr_pkg::BLOCK_LEN_RST;
            r_fill      <= '0;
            r_pass      <= '0;
            r_phase     <= 1'b1;
            r_end       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_block_len <= i_cfg_block_len;
            end
            if (i_cmd.accept) begin
                if (r_phase) begin
                    r_fill <= CW'(w_fill_inc);
                    r_end  <= i_list_end;
                    if (o_sts.go_drain) begin
                        r_phase <= i_list_end;
                        r_pass  <= '0;
                    end
                end else if (w_pass_end) begin
                    r_phase <= 1'b1;
                    r_pass  <= '0;
                end else begin
                    r_pass <= CW'(w_pass_inc);
                end
            end
            if (i_cmd.read_step) begin
                r_fill <= n_fill_dec;
            end
        end
    end

    // stack buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_phase) begin
            r_mem[r_fill[AW-1:0]] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !r_phase) begin
            r_out_value <= i_value;
            r_out_last  <= 1'b1;
            r_out_done  <= i_list_end;
        end else if (i_cmd.read_step) begin
            r_out_value <= r_mem[n_fill_dec[AW-1:0]];
            r_out_last  <= (n_fill_dec == '0);
            r_out_done  <= r_end && (n_fill_dec == '0);
        end
    end

    assign o_value_res = r_out_value;
    assign o_run_last  = r_out_last;
    assign o_list_done = r_out_done;

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.read_step |-> r_fill != '0)
        else $error("read step on empty stack");

    a_pass_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && !r_phase) |-> r_fill == '0)
        else $error("stack not empty in pass block");

endmodule

`default_nettype wire

/* sv/alternating_block_reverser.sv */
// a pass-block element is registered and shown in the cycle after its input beat
// a reversed block: after the closing beat, a stack read then an output beat per element
// one held element per cycle; a pass-block element takes an input beat then an output beat
// draining takes a stack read and an output beat per element, input stalled meanwhile
// reset: synchronous active low, clears counters, phase to holding, block_len to 2, stack contents kept
`timescale 1ns / 1ps
`default_nettype none

module alternating_block_reverser #(
    parameter int MAX_K = abr_pkg::MAX_K_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [abr_pkg::VALUE_W-1:0] i_value,
    input  wire logic                               i_list_end,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [abr_pkg::VALUE_W-1:0]      o_value_res,
    output logic                                    o_run_last,
    output logic                                    o_list_done,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [abr_pkg::LEN_W-1:0]          i_cfg_block_len
);

    abr_pkg::t_cmd w_cmd;
    abr_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    abr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    abr_datapath #(
        .MAX_K (MAX_K)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_block_len (i_cfg_block_len),
        .i_value         (i_value),
        .i_list_end      (i_list_end),
        .o_value_res     (o_value_res),
        .o_run_last      (o_run_last),
        .o_list_done     (o_list_done)
    );

endmodule

`default_nettype wire
